>>> src/sps_pkg.sv
// Shared types, constants and helpers for the five-state process scheduler.
// No dependencies; sps_ctrl, sps_dp and the top level refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package sps_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam logic [3:0]  BLOCK_DELAY_RST = 4'd5;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_ADMIT = 2'd1,
    FUNC_BLOCK = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    EV_ADMIT     = 3'd0,
    EV_REJECT    = 3'd1,
    EV_DISPATCH  = 3'd2,
    EV_EXIT      = 3'd3,
    EV_PREEMPT   = 3'd4,
    EV_BLOCK     = 3'd5,
    EV_UNBLOCK   = 3'd6,
    EV_UNUSED    = 3'd7
  } event_e;

  typedef struct packed {
    logic [7:0]  tag;
    logic [15:0] life;
    logic [15:0] slice;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic latch;
    logic decode;
    logic charge;
    logic start;
    logic release_blk;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
    logic pend_v;
    logic is_tick;
  } status_t;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [15:0] elapsed(input logic [31:0] now,
                                           input logic [31:0] stamp);
    logic [31:0] d;
    d = now - stamp;
    return (d > 32'd65535) ? 16'hFFFF : d[15:0];
  endfunction

endpackage
`default_nettype wire

>>> src/sps_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module sps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> src/sps_ctrl.sv
// Sequencer for the scheduler: walks each input word through its phases.
// Depends on sps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sps_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire sps_pkg::status_t sts_i,
  output sps_pkg::cmd_t         cmd_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_CHARGE, S_RDHEAD, S_START, S_RELEASE, S_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.slot_free) begin
          cmd_o.decode = 1'b1;
          state_d      = sts_i.is_tick ? S_CHARGE : S_FINISH;
        end
      end
      S_CHARGE: begin
        if (sts_i.slot_free) begin
          cmd_o.charge = 1'b1;
          state_d      = S_RDHEAD;
        end
      end
      S_RDHEAD: state_d = S_START;
      S_START: begin
        if (sts_i.slot_free) begin
          cmd_o.start = 1'b1;
          state_d     = S_RELEASE;
        end
      end
      S_RELEASE: begin
        if (sts_i.slot_free) begin
          cmd_o.release_blk = 1'b1;
          state_d           = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!sts_i.pend_v) begin
          state_d = S_IDLE;
        end else if (sts_i.slot_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // a new word only starts once the previous word's results are all out of hold
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !sts_i.pend_v) else $error("pending result left at idle");
  a_finish_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> (state_q == S_IDLE)) else $error("finish did not return to idle");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o)) else $error("more than one command at once");
endmodule
`default_nettype wire

>>> src/sps_dp.sv
// Scheduler datapath: CPU slot, ready/blocked FIFOs, tick counter, result staging.
// Depends on sps_pkg and sps_ram.
`timescale 1ns / 1ps
`default_nettype none
module sps_dp (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [3:0]       cfg_wdata_i,
  input  wire logic [1:0]       func_i,
  input  wire logic [7:0]       proc_id_i,
  input  wire logic [15:0]      lifetime_i,
  input  wire logic [15:0]      run_slice_i,
  input  wire sps_pkg::cmd_t    cmd_i,
  output sps_pkg::status_t      sts_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [2:0]            event_res_o,
  output logic [7:0]            proc_id_res_o,
  output logic [15:0]           time_in_state_o,
  output logic                  last_o
);
  localparam int unsigned PW = sps_pkg::PTR_W;
  localparam int unsigned CW = sps_pkg::CNT_W;
  localparam logic [CW-1:0] FULL = CW'(sps_pkg::QUEUE_DEPTH);

  logic [1:0]  func_q;
  logic [7:0]  tag_in_q;
  logic [15:0] life_in_q, slice_in_q;
  logic [3:0]  delay_q;

  logic [PW-1:0] r_head_q, r_head_d, r_tail_q, r_tail_d;
  logic [CW-1:0] r_cnt_q, r_cnt_d;
  logic [PW-1:0] b_head_q, b_head_d, b_tail_q, b_tail_d;
  logic [CW-1:0] b_cnt_q, b_cnt_d;

  logic        busy_q, busy_d;
  logic [7:0]  ctag_q, ctag_d;
  logic [15:0] clife_q, clife_d, cslice_q, cslice_d, ctime_q, ctime_d;
  logic [3:0]  bwait_q, bwait_d;
  logic [31:0] tick_q, tick_d;

  logic        pend_v_q, pend_v_d;
  logic [2:0]  pend_ev_q, pend_ev_d;
  logic [7:0]  pend_tag_q, pend_tag_d;
  logic [15:0] pend_time_q, pend_time_d;

  logic        out_v_q, out_v_d, out_last_q, out_last_d;
  logic [2:0]  out_ev_q, out_ev_d;
  logic [7:0]  out_tag_q, out_tag_d;
  logic [15:0] out_time_q, out_time_d;

  logic            r_we, b_we;
  logic [PW-1:0]   r_waddr;
  sps_pkg::entry_t r_wdata, b_wdata, r_rdata, b_rdata;

  logic        emit_v;
  logic [2:0]  emit_ev;
  logic [7:0]  emit_tag;
  logic [15:0] emit_time;
  logic [15:0] time_inc, life_dec;
  logic [3:0]  wait_inc;

  assign time_inc = (ctime_q == 16'hFFFF) ? ctime_q : ctime_q + 16'd1;
  assign life_dec = clife_q - 16'd1;
  assign wait_inc = (bwait_q == 4'hF) ? bwait_q : bwait_q + 4'd1;

  always_comb begin
    r_head_d = r_head_q;  r_tail_d = r_tail_q;  r_cnt_d = r_cnt_q;
    b_head_d = b_head_q;  b_tail_d = b_tail_q;  b_cnt_d = b_cnt_q;
    busy_d = busy_q;  ctag_d = ctag_q;  clife_d = clife_q;
    cslice_d = cslice_q;  ctime_d = ctime_q;
    bwait_d = bwait_q;  tick_d = tick_q;
    r_we = 1'b0;  r_waddr = r_tail_q;  r_wdata = '0;
    b_we = 1'b0;  b_wdata = '0;
    emit_v = 1'b0;  emit_ev = sps_pkg::EV_ADMIT;  emit_tag = '0;  emit_time = '0;

    if (cmd_i.decode) begin
      case (sps_pkg::func_e'(func_q))
        sps_pkg::FUNC_ADMIT: begin
          emit_v   = 1'b1;
          emit_tag = tag_in_q;
          if (r_cnt_q >= FULL) begin
            emit_ev = sps_pkg::EV_REJECT;
          end else begin
            emit_ev  = sps_pkg::EV_ADMIT;
            r_we     = 1'b1;
            r_wdata  = '{tag: tag_in_q, life: life_in_q, slice: slice_in_q, stamp: tick_q};
            r_tail_d = sps_pkg::next_ptr(r_tail_q);
            r_cnt_d  = r_cnt_q + 1'b1;
          end
        end
        sps_pkg::FUNC_BLOCK: begin
          if (busy_q && b_cnt_q < FULL) begin
            b_we      = 1'b1;
            b_wdata   = '{tag: ctag_q, life: clife_q, slice: cslice_q, stamp: tick_q};
            b_tail_d  = sps_pkg::next_ptr(b_tail_q);
            b_cnt_d   = b_cnt_q + 1'b1;
            emit_v    = 1'b1;
            emit_ev   = sps_pkg::EV_BLOCK;
            emit_tag  = ctag_q;
            emit_time = ctime_q;
            busy_d    = 1'b0;
          end
        end
        default: ;
      endcase
    end

    if (cmd_i.charge) begin
      tick_d = tick_q + 32'd1;
      if (busy_q) begin
        ctime_d = time_inc;
        clife_d = life_dec;
        if (clife_q <= 16'd1 || cslice_q == 16'd0) begin
          emit_v = 1'b1;  emit_ev = sps_pkg::EV_EXIT;
          emit_tag = ctag_q;  emit_time = time_inc;
          busy_d = 1'b0;
        end else if (time_inc >= cslice_q && r_cnt_q < FULL) begin
          r_we     = 1'b1;
          r_wdata  = '{tag: ctag_q, life: life_dec, slice: cslice_q, stamp: tick_q + 32'd1};
          r_tail_d = sps_pkg::next_ptr(r_tail_q);
          r_cnt_d  = r_cnt_q + 1'b1;
          emit_v = 1'b1;  emit_ev = sps_pkg::EV_PREEMPT;
          emit_tag = ctag_q;  emit_time = time_inc;
          busy_d = 1'b0;
        end
      end
    end

    if (cmd_i.start && !busy_q && r_cnt_q != '0) begin
      emit_v    = 1'b1;
      emit_ev   = sps_pkg::EV_DISPATCH;
      emit_tag  = r_rdata.tag;
      emit_time = sps_pkg::elapsed(tick_q, r_rdata.stamp);
      ctag_d    = r_rdata.tag;
      clife_d   = r_rdata.life;
      cslice_d  = r_rdata.slice;
      ctime_d   = '0;
      busy_d    = 1'b1;
      r_head_d  = sps_pkg::next_ptr(r_head_q);
      r_cnt_d   = r_cnt_q - 1'b1;
    end

    if (cmd_i.release_blk && b_cnt_q != '0) begin
      bwait_d = wait_inc;
      if (wait_inc >= delay_q && r_cnt_q < FULL) begin
        emit_v    = 1'b1;
        emit_ev   = sps_pkg::EV_UNBLOCK;
        emit_tag  = b_rdata.tag;
        emit_time = sps_pkg::elapsed(tick_q, b_rdata.stamp);
        r_we      = 1'b1;
        r_wdata   = '{tag: b_rdata.tag, life: b_rdata.life, slice: b_rdata.slice,
                      stamp: tick_q};
        r_tail_d  = sps_pkg::next_ptr(r_tail_q);
        r_cnt_d   = r_cnt_q + 1'b1;
        b_head_d  = sps_pkg::next_ptr(b_head_q);
        b_cnt_d   = b_cnt_q - 1'b1;
        bwait_d   = '0;
      end
    end
  end

  // result staging: the newest word waits in hold until the next one (last=0)
  // or the end of the input word (last=1) pushes it to the output register
  always_comb begin
    pend_v_d = pend_v_q;  pend_ev_d = pend_ev_q;
    pend_tag_d = pend_tag_q;  pend_time_d = pend_time_q;
    out_v_d = out_v_q && !out_ready_i;
    out_ev_d = out_ev_q;  out_tag_d = out_tag_q;
    out_time_d = out_time_q;  out_last_d = out_last_q;
    if (emit_v) begin
      if (pend_v_q) begin
        out_v_d = 1'b1;  out_ev_d = pend_ev_q;  out_tag_d = pend_tag_q;
        out_time_d = pend_time_q;  out_last_d = 1'b0;
      end
      pend_v_d = 1'b1;  pend_ev_d = emit_ev;
      pend_tag_d = emit_tag;  pend_time_d = emit_time;
    end else if (cmd_i.finish && pend_v_q) begin
      out_v_d = 1'b1;  out_ev_d = pend_ev_q;  out_tag_d = pend_tag_q;
      out_time_d = pend_time_q;  out_last_d = 1'b1;
      pend_v_d = 1'b0;
    end
  end

  sps_ram #(.WIDTH($bits(sps_pkg::entry_t)), .DEPTH(sps_pkg::QUEUE_DEPTH)) u_ready_ram (
    .clk_i, .we_i(r_we), .waddr_i(r_waddr), .wdata_i(r_wdata),
    .raddr_i(r_head_q), .rdata_o(r_rdata)
  );

  sps_ram #(.WIDTH($bits(sps_pkg::entry_t)), .DEPTH(sps_pkg::QUEUE_DEPTH)) u_blocked_ram (
    .clk_i, .we_i(b_we), .waddr_i(b_tail_q), .wdata_i(b_wdata),
    .raddr_i(b_head_q), .rdata_o(b_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q     <= func_i;
      tag_in_q   <= proc_id_i;
      life_in_q  <= lifetime_i;
      slice_in_q <= run_slice_i;
    end
    pend_ev_q   <= pend_ev_d;
    pend_tag_q  <= pend_tag_d;
    pend_time_q <= pend_time_d;
    out_ev_q    <= out_ev_d;
    out_tag_q   <= out_tag_d;
    out_time_q  <= out_time_d;
    out_last_q  <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q  <= sps_pkg::BLOCK_DELAY_RST;
      r_head_q <= '0;  r_tail_q <= '0;  r_cnt_q <= '0;
      b_head_q <= '0;  b_tail_q <= '0;  b_cnt_q <= '0;
      busy_q <= 1'b0;  ctag_q <= '0;  clife_q <= '0;
      cslice_q <= '0;  ctime_q <= '0;
      bwait_q <= '0;  tick_q <= '0;
      pend_v_q <= 1'b0;  out_v_q <= 1'b0;
    end else begin
      if (cfg_we_i) delay_q <= cfg_wdata_i;
      r_head_q <= r_head_d;  r_tail_q <= r_tail_d;  r_cnt_q <= r_cnt_d;
      b_head_q <= b_head_d;  b_tail_q <= b_tail_d;  b_cnt_q <= b_cnt_d;
      busy_q <= busy_d;  ctag_q <= ctag_d;  clife_q <= clife_d;
      cslice_q <= cslice_d;  ctime_q <= ctime_d;
      bwait_q <= bwait_d;  tick_q <= tick_d;
      pend_v_q <= pend_v_d;  out_v_q <= out_v_d;
    end
  end

  assign sts_o.slot_free = !out_v_q || out_ready_i;
  assign sts_o.pend_v    = pend_v_q;
  assign sts_o.is_tick   = (func_q == sps_pkg::FUNC_TICK);

  assign out_valid_o     = out_v_q;
  assign event_res_o     = out_ev_q;
  assign proc_id_res_o   = out_tag_q;
  assign time_in_state_o = out_time_q;
  assign last_o          = out_last_q;

  a_rcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_cnt_q <= FULL) else $error("ready count overflow");
  a_bcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_cnt_q <= FULL) else $error("blocked count overflow");
  a_rptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (r_cnt_q == '0 || r_cnt_q == FULL) |-> (r_head_q == r_tail_q))
    else $error("ready pointers disagree with count");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_v && pend_v_q) |-> (!out_v_q || out_ready_i))
    else $error("result overwrote an untaken word");
endmodule
`default_nettype wire

>>> src/five_state_process_scheduler.sv
// Top level of the five-state process scheduler: sequencer plus datapath.
// Depends on sps_pkg, sps_ctrl, sps_dp (which holds two sps_ram FIFOs).
`timescale 1ns / 1ps
`default_nettype none
// Each input word is a command: func 0 advances time by one tick, func 1 admits
// a process to the ready queue, func 2 moves the running process to the blocked
// queue. The block answers with up to three result words, the final one marked
// by last_o; a block or unknown command that changes nothing gives no result.
// One word is handled at a time. An admit, a block or a command with no result
// passes through decode and finish before ready returns; a tick also passes
// through charge, head read, start and release. The phases follow from the
// controller's sequence and the registered read of the queue memories, and
// stretch only while the output is stalled: a phase that may emit waits until
// the output register's word is taken; one further result word is held back.
// block_delay (cfg_we_i / cfg_wdata_i, reset 5) may be written while idle.
module five_state_process_scheduler (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [3:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [7:0]  proc_id_i,
  input  wire logic [15:0] lifetime_i,
  input  wire logic [15:0] run_slice_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       event_res_o,
  output logic [7:0]       proc_id_res_o,
  output logic [15:0]      time_in_state_o,
  output logic             last_o
);
  sps_pkg::cmd_t    cmd;
  sps_pkg::status_t sts;

  // sequencer: decode, charge, dispatch, release, then flush the held word
  sps_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .sts_i(sts), .cmd_o(cmd)
  );

  sps_dp u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .func_i, .proc_id_i, .lifetime_i, .run_slice_i,
    .cmd_i(cmd), .sts_o(sts),
    .out_valid_o, .out_ready_i, .event_res_o, .proc_id_res_o,
    .time_in_state_o, .last_o
  );
endmodule
`default_nettype wire
